// ===== hw/rtl/hashed_name_flag_store_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the hashed name flag store
// Implication checks on clk, disabled while rst_n is low. Define ASSERT_OFF
// to compile them away.
// ----------------------------------------------------------------------------
`ifndef HASHED_NAME_FLAG_STORE_ASSERT_SVH
`define HASHED_NAME_FLAG_STORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define HNFS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hnfs: same-cycle check failed");
`define HNFS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hnfs: next-cycle check failed");
`else
`define HNFS_ASSERT_IMP(lbl, ante, cons)
`define HNFS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/hnfs_pkg.sv =====
// ----------------------------------------------------------------------------
// hnfs_pkg
// Shared types and constants of the hashed name flag store.
// ----------------------------------------------------------------------------
package hnfs_pkg;

  localparam int unsigned NAME_W    = 8;
  localparam int unsigned HASH_W    = 32;
  localparam int unsigned OUT_IDX_W = 10;
  localparam int unsigned ROW_SEL_W = 4;
  localparam int unsigned ROW_BITS  = 16;

  localparam logic [HASH_W-1:0] HASH_BASIS    = 32'h811C_9DC5;
  localparam logic [HASH_W-1:0] HASH_PRIME    = 32'h0100_0193;
  // prime squared, modulo 2^32
  localparam logic [HASH_W-1:0] HASH_PRIME_SQ = 32'h2602_7A69;

  localparam logic ACT_BYTE   = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;
  localparam logic PART_GROUP = 1'b0;
  localparam logic PART_KEY   = 1'b1;

  typedef enum logic [1:0] {
    KIND_CLEAR,
    KIND_INVALID,
    KIND_ACCESS
  } kind_t;

  typedef struct packed {
    logic  valid;
    kind_t kind;
    logic  wen;
    logic  wval;
  } hnfs_ctl_t;

  typedef struct packed {
    logic                 access_valid;
    logic                 flag_before;
    logic                 flag_after;
    logic [OUT_IDX_W-1:0] bit_index;
  } hnfs_res_t;

endpackage

// ===== hw/rtl/hnfs_hash.sv =====
// ----------------------------------------------------------------------------
// hnfs_hash
// FNV-1a name hashing, one beat per cycle while adv is high. The hash is kept before its last
// multiply, so the group/key boundary costs one multiply by the squared prime.
// ----------------------------------------------------------------------------
module hnfs_hash (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        beat_vld,
  input  logic                        action,
  input  logic                        name_part,
  input  logic [hnfs_pkg::NAME_W-1:0] name_byte,
  input  logic                        last_byte,
  input  logic                        write_enable,
  input  logic                        write_value,
  output hnfs_pkg::hnfs_ctl_t         b_ctl,
  output logic [hnfs_pkg::HASH_W-1:0] b_pre
);
  import hnfs_pkg::*;

  logic [HASH_W-1:0] x_r, x_nxt;
  logic              pend_r, pend_nxt;
  logic              group_r, group_nxt;
  logic              key_r, key_nxt;
  hnfs_ctl_t         ctl_r, ctl_nxt;
  logic [HASH_W-1:0] pre_r, pre_nxt;
  logic [HASH_W-1:0] m1, m2, h_cur, h_bnd, byte_ext;

  assign m1 = x_r * HASH_PRIME;
  assign m2 = x_r * HASH_PRIME_SQ;

  always_comb begin
    h_cur     = pend_r ? m1 : x_r;
    h_bnd     = pend_r ? m2 : m1;
    byte_ext  = HASH_W'(name_byte);
    x_nxt     = x_r;
    pend_nxt  = pend_r;
    group_nxt = group_r;
    key_nxt   = key_r;
    ctl_nxt   = '0;
    pre_nxt   = x_r;
    if (action == ACT_CLEAR) begin
      x_nxt        = HASH_BASIS;
      pend_nxt     = 1'b0;
      group_nxt    = 1'b0;
      key_nxt      = 1'b0;
      ctl_nxt.valid = 1'b1;
      ctl_nxt.kind  = KIND_CLEAR;
    end else begin
      if (name_part == PART_GROUP) begin
        if (!key_r) begin
          x_nxt     = h_cur ^ byte_ext;
          pend_nxt  = 1'b1;
          group_nxt = 1'b1;
        end
      end else begin
        x_nxt    = (key_r ? h_cur : h_bnd) ^ byte_ext;
        pend_nxt = 1'b1;
        key_nxt  = 1'b1;
      end
      pre_nxt = x_nxt;
      if (last_byte) begin
        ctl_nxt.valid = 1'b1;
        ctl_nxt.kind  = (group_nxt && key_nxt) ? KIND_ACCESS : KIND_INVALID;
        ctl_nxt.wen   = write_enable;
        ctl_nxt.wval  = write_value;
        x_nxt         = HASH_BASIS;
        pend_nxt      = 1'b0;
        group_nxt     = 1'b0;
        key_nxt       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r     <= HASH_BASIS;
      pend_r  <= 1'b0;
      group_r <= 1'b0;
      key_r   <= 1'b0;
      ctl_r   <= '0;
    end else if (adv) begin
      if (beat_vld) begin
        x_r     <= x_nxt;
        pend_r  <= pend_nxt;
        group_r <= group_nxt;
        key_r   <= key_nxt;
      end
      ctl_r <= beat_vld ? ctl_nxt : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pre_r <= pre_nxt;
    end
  end

  assign b_ctl = ctl_r;
  assign b_pre = pre_r;

endmodule

// ===== hw/rtl/hnfs_mod.sv =====
// ----------------------------------------------------------------------------
// hnfs_mod
// Final hash multiply and reduction modulo FLAG_BITS by reciprocal multiply
// with one correction step, over three register stages.
// ----------------------------------------------------------------------------
module hnfs_mod #(
  parameter int unsigned FLAG_BITS = 616,
  localparam int unsigned IDX_W = $clog2(FLAG_BITS)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  hnfs_pkg::hnfs_ctl_t         b_ctl,
  input  logic [hnfs_pkg::HASH_W-1:0] b_pre,
  output hnfs_pkg::hnfs_ctl_t         e_ctl,
  output logic [IDX_W-1:0]            e_idx
);
  import hnfs_pkg::*;

  localparam logic [63:0]       RECIP_WIDE = 64'h1_0000_0000 / 64'(FLAG_BITS);
  localparam logic [HASH_W-1:0] RECIP      = RECIP_WIDE[HASH_W-1:0];
  localparam logic [HASH_W-1:0] DIVISOR    = HASH_W'(FLAG_BITS);

  hnfs_ctl_t         c_ctl_r, d_ctl_r, e_ctl_r;
  logic [HASH_W-1:0] c_hash_r, c_hash_nxt;
  logic [HASH_W-1:0] d_hash_r, d_quot_r, d_quot_nxt;
  logic [IDX_W-1:0]  e_idx_r, e_idx_nxt;
  logic [63:0]       prod;
  logic [HASH_W-1:0] rem_est, rem;

  assign c_hash_nxt = b_pre * HASH_PRIME;
  assign prod       = 64'(c_hash_r) * 64'(RECIP);
  assign d_quot_nxt = prod[63:HASH_W];

  always_comb begin
    rem_est   = d_hash_r - d_quot_r * DIVISOR;
    rem       = (rem_est >= DIVISOR) ? rem_est - DIVISOR : rem_est;
    e_idx_nxt = IDX_W'(rem);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_ctl_r <= '0;
      d_ctl_r <= '0;
      e_ctl_r <= '0;
    end else if (adv) begin
      c_ctl_r <= b_ctl;
      d_ctl_r <= c_ctl_r;
      e_ctl_r <= d_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_hash_r <= c_hash_nxt;
      d_hash_r <= c_hash_r;
      d_quot_r <= d_quot_nxt;
      e_idx_r  <= e_idx_nxt;
    end
  end

  assign e_ctl = e_ctl_r;
  assign e_idx = e_idx_r;

endmodule

// ===== hw/rtl/hnfs_bitmap.sv =====
// ----------------------------------------------------------------------------
// hnfs_bitmap
// Flag bitmap in a RAM of 16-bit rows with a valid flop per row. Read the
// row, modify one bit, write it back; forward the last written row.
// ----------------------------------------------------------------------------
module hnfs_bitmap #(
  parameter int unsigned FLAG_BITS = 616,
  localparam int unsigned IDX_W = $clog2(FLAG_BITS)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  hnfs_pkg::hnfs_ctl_t e_ctl,
  input  logic [IDX_W-1:0]    e_idx,
  output logic                f_vld,
  output hnfs_pkg::hnfs_res_t f_res
);
  import hnfs_pkg::*;

  localparam int unsigned ROWS  = (FLAG_BITS + ROW_BITS - 1) / ROW_BITS;
  localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned EXT_W = IDX_W + OUT_IDX_W;

  logic [ROW_BITS-1:0]  mem [ROWS];
  logic [ROWS-1:0]      row_vld_r;
  hnfs_ctl_t            f_ctl_r;
  logic [IDX_W-1:0]     f_idx_r;
  logic [ROW_BITS-1:0]  f_rdata_r;
  logic                 fwd_vld_r;
  logic [ROW_W-1:0]     fwd_row_r;
  logic [ROW_BITS-1:0]  fwd_data_r;
  logic [EXT_W-1:0]     e_ext, f_ext;
  logic [ROW_W-1:0]     e_row, f_row;
  logic [ROW_SEL_W-1:0] bit_sel;
  logic [ROW_BITS-1:0]  row_cur, row_new;
  logic                 is_access, wr_en, prior, after;

  always_comb begin
    e_ext     = EXT_W'(e_idx);
    f_ext     = EXT_W'(f_idx_r);
    e_row     = ROW_W'(e_ext >> ROW_SEL_W);
    f_row     = ROW_W'(f_ext >> ROW_SEL_W);
    bit_sel   = f_ext[ROW_SEL_W-1:0];
    is_access = f_ctl_r.valid && (f_ctl_r.kind == KIND_ACCESS);
    wr_en     = adv && is_access;
    if (fwd_vld_r && (fwd_row_r == f_row)) begin
      row_cur = fwd_data_r;
    end else if (row_vld_r[f_row]) begin
      row_cur = f_rdata_r;
    end else begin
      row_cur = '0;
    end
    prior            = row_cur[bit_sel];
    after            = f_ctl_r.wen ? f_ctl_r.wval : prior;
    row_new          = row_cur;
    row_new[bit_sel] = after;
  end

  always_comb begin
    f_vld = f_ctl_r.valid;
    f_res = '0;
    case (f_ctl_r.kind)
      KIND_ACCESS: begin
        f_res.access_valid = 1'b1;
        f_res.flag_before  = prior;
        f_res.flag_after   = after;
        f_res.bit_index    = f_ext[OUT_IDX_W-1:0];
      end
      default: begin
        f_res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[f_row] <= row_new;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_rdata_r  <= mem[e_row];
      f_idx_r    <= e_idx;
      fwd_row_r  <= f_row;
      fwd_data_r <= row_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      f_ctl_r   <= '0;
      fwd_vld_r <= 1'b0;
    end else if (adv) begin
      f_ctl_r   <= e_ctl;
      fwd_vld_r <= is_access;
      if (f_ctl_r.valid && (f_ctl_r.kind == KIND_CLEAR)) begin
        row_vld_r <= '0;
      end else if (is_access) begin
        row_vld_r[f_row] <= 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/hashed_name_flag_store.sv =====
// ----------------------------------------------------------------------------
// hashed_name_flag_store
// Bit flags addressed by the FNV-1a hash of a group name and a key name.
// ----------------------------------------------------------------------------
// Stream name bytes in, one beat each, group bytes first, then key bytes;
// the beat with last_byte set reads the flag at hash mod FLAG_BITS and
// optionally writes it, and returns one result beat. A clear beat wipes all
// flags, drops any name in progress, and returns an all-zero result; an
// access with an empty group or key returns all zeros and changes nothing.
// One beat is taken every cycle while in_stall is low. That rate rests on
// the hash recurrence needing only one constant multiply per byte; the
// reduction modulo FLAG_BITS and the bitmap read-modify-write run in the
// stages behind it. Flags live in a RAM of 16-bit rows with one valid flop
// per row, so clear takes effect at once and no clearing pass follows reset.
// ----------------------------------------------------------------------------
`include "hashed_name_flag_store_assert.svh"

module hashed_name_flag_store #(
  parameter int unsigned FLAG_BITS = 616
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_action,
  input  logic                           in_name_part,
  input  logic [hnfs_pkg::NAME_W-1:0]    in_name_byte,
  input  logic                           in_last_byte,
  input  logic                           in_write_enable,
  input  logic                           in_write_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_access_valid,
  output logic                           out_flag_before,
  output logic                           out_flag_after,
  output logic [hnfs_pkg::OUT_IDX_W-1:0] out_bit_index
);
  import hnfs_pkg::*;

  localparam int unsigned IDX_W = $clog2(FLAG_BITS);

  logic              adv;
  logic              a_vld_r;
  logic              a_action_r, a_part_r, a_last_r, a_wen_r, a_wval_r;
  logic [NAME_W-1:0] a_byte_r;
  hnfs_ctl_t         b_ctl, e_ctl;
  logic [HASH_W-1:0] b_pre;
  logic [IDX_W-1:0]  e_idx;
  logic              f_vld;
  hnfs_res_t         f_res;
  logic              out_valid_r;
  hnfs_res_t         out_res_r;

  // advance the whole pipeline unless a result is held at the output
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      a_vld_r     <= in_valid;
      out_valid_r <= f_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_action_r <= in_action;
      a_part_r   <= in_name_part;
      a_byte_r   <= in_name_byte;
      a_last_r   <= in_last_byte;
      a_wen_r    <= in_write_enable;
      a_wval_r   <= in_write_value;
      out_res_r  <= f_res;
    end
  end

  hnfs_hash u_hash (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .beat_vld     (a_vld_r),
    .action       (a_action_r),
    .name_part    (a_part_r),
    .name_byte    (a_byte_r),
    .last_byte    (a_last_r),
    .write_enable (a_wen_r),
    .write_value  (a_wval_r),
    .b_ctl        (b_ctl),
    .b_pre        (b_pre)
  );

  hnfs_mod #(
    .FLAG_BITS (FLAG_BITS)
  ) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .b_ctl (b_ctl),
    .b_pre (b_pre),
    .e_ctl (e_ctl),
    .e_idx (e_idx)
  );

  hnfs_bitmap #(
    .FLAG_BITS (FLAG_BITS)
  ) u_bitmap (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .e_ctl (e_ctl),
    .e_idx (e_idx),
    .f_vld (f_vld),
    .f_res (f_res)
  );

  assign out_valid        = out_valid_r;
  assign out_access_valid = out_res_r.access_valid;
  assign out_flag_before  = out_res_r.flag_before;
  assign out_flag_after   = out_res_r.flag_after;
  assign out_bit_index    = out_res_r.bit_index;

  `HNFS_ASSERT_IMP(a_idx_in_range, e_ctl.valid && (e_ctl.kind == KIND_ACCESS), 32'(e_idx) < FLAG_BITS)
  `HNFS_ASSERT_IMP(a_inval_zero, out_valid_r && !out_res_r.access_valid, !out_res_r.flag_before && !out_res_r.flag_after && (out_res_r.bit_index == '0))
  `HNFS_ASSERT_NXT(a_pipe_hold, !adv, $stable(e_idx) && $stable(e_ctl))

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb: hashed name flag store testbench
// Streams group and key name bytes, clears and malformed names into the
// store, predicts every result beat with an FNV-1a hash and a flag bitmap of
// its own, and checks each result field. Both sides idle and stall at
// random; the receiver also holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hnfs_pkg::*;

  localparam int unsigned NUM_FLAGS   = 616;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned POOL_SIZE   = 8;

  typedef struct packed {
    logic              action;
    logic              name_part;
    logic [NAME_W-1:0] name_byte;
    logic              last_byte;
    logic              write_enable;
    logic              write_value;
  } name_beat_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_action = 1'b0;
  logic                 in_name_part = 1'b0;
  logic [NAME_W-1:0]    in_name_byte = '0;
  logic                 in_last_byte = 1'b0;
  logic                 in_write_enable = 1'b0;
  logic                 in_write_value = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_access_valid;
  logic                 out_flag_before;
  logic                 out_flag_after;
  logic [OUT_IDX_W-1:0] out_bit_index;

  name_beat_t  pending_beats[$];
  hnfs_res_t   expected_results[$];
  name_beat_t  next_beat;
  int unsigned total_beats = 0;
  int unsigned beats_issued = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  logic [HASH_W-1:0] fnv_hash = HASH_BASIS;
  bit                grp_seen = 1'b0;
  bit                key_seen = 1'b0;
  bit                flags[NUM_FLAGS];

  logic [NAME_W-1:0] pool_grp[POOL_SIZE][4];
  logic [NAME_W-1:0] pool_key[POOL_SIZE][4];
  int unsigned       pool_grp_len[POOL_SIZE];
  int unsigned       pool_key_len[POOL_SIZE];

  hashed_name_flag_store #(
    .FLAG_BITS(NUM_FLAGS)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_name_part    (in_name_part),
    .in_name_byte    (in_name_byte),
    .in_last_byte    (in_last_byte),
    .in_write_enable (in_write_enable),
    .in_write_value  (in_write_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_access_valid(out_access_valid),
    .out_flag_before (out_flag_before),
    .out_flag_after  (out_flag_after),
    .out_bit_index   (out_bit_index)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [HASH_W-1:0] fnv_fold(input logic [HASH_W-1:0] h,
                                                 input logic [NAME_W-1:0] c);
    logic [HASH_W-1:0] mixed;
    mixed = h ^ {{(HASH_W-NAME_W){1'b0}}, c};
    return mixed * HASH_PRIME;
  endfunction

  function automatic bit predict_flag_access(input name_beat_t b, output hnfs_res_t r);
    int unsigned idx;
    r = '0;
    if (b.action == ACT_CLEAR) begin
      foreach (flags[i]) flags[i] = 1'b0;
    end else begin
      if (b.name_part == PART_GROUP) begin
        if (!key_seen) begin
          fnv_hash = fnv_fold(fnv_hash, b.name_byte);
          grp_seen = 1'b1;
        end
      end else begin
        if (!key_seen) begin
          fnv_hash = fnv_fold(fnv_hash, '0);
          key_seen = 1'b1;
        end
        fnv_hash = fnv_fold(fnv_hash, b.name_byte);
      end
      if (!b.last_byte) return 1'b0;
      if (grp_seen && key_seen) begin
        idx = fnv_hash % NUM_FLAGS;
        r.access_valid = 1'b1;
        r.flag_before = flags[idx];
        if (b.write_enable) flags[idx] = b.write_value;
        r.flag_after = flags[idx];
        r.bit_index = idx[OUT_IDX_W-1:0];
      end
    end
    fnv_hash = HASH_BASIS;
    grp_seen = 1'b0;
    key_seen = 1'b0;
    return 1'b1;
  endfunction

  function automatic int unsigned idle_pct(input bit sender_side, input int unsigned issued);
    if (issued < total_beats / 3) return sender_side ? 13 : 77;
    if (issued < 2 * total_beats / 3) return sender_side ? 77 : 13;
    return 0;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    mismatches++;
  endtask

  task automatic push_beat(input logic action, input logic part, input logic [NAME_W-1:0] c,
                           input logic last, input logic wen, input logic wval);
    name_beat_t b;
    b.action = action;
    b.name_part = part;
    b.name_byte = c;
    b.last_byte = last;
    b.write_enable = wen;
    b.write_value = wval;
    pending_beats.push_back(b);
  endtask

  // p < 0 picks fresh random bytes; late_group appends a group byte that ends the access
  task automatic push_name(input int p, input int unsigned gl, input int unsigned kl,
                           input bit late_group, input bit wen, input bit wval);
    logic [NAME_W-1:0] c;
    bit                ends;
    for (int unsigned i = 0; i < gl; i++) begin
      c = (p >= 0) ? pool_grp[p][i] : NAME_W'($urandom_range(0, 255));
      ends = (kl == 0) && (i == gl - 1) && !late_group;
      if (ends) push_beat(ACT_BYTE, PART_GROUP, c, 1'b1, wen, wval);
      else push_beat(ACT_BYTE, PART_GROUP, c, 1'b0, 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
    end
    for (int unsigned i = 0; i < kl; i++) begin
      c = (p >= 0) ? pool_key[p][i] : NAME_W'($urandom_range(0, 255));
      ends = (i == kl - 1) && !late_group;
      if (ends) push_beat(ACT_BYTE, PART_KEY, c, 1'b1, wen, wval);
      else push_beat(ACT_BYTE, PART_KEY, c, 1'b0, 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
    end
    if (late_group)
      push_beat(ACT_BYTE, PART_GROUP, NAME_W'($urandom_range(0, 255)), 1'b1, wen, wval);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_beats.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b1, beats_issued)) begin
        next_beat = pending_beats.pop_front();
        in_valid <= 1'b1;
        in_action <= next_beat.action;
        in_name_part <= next_beat.name_part;
        in_name_byte <= next_beat.name_byte;
        in_last_byte <= next_beat.last_byte;
        in_write_enable <= next_beat.write_enable;
        in_write_value <= next_beat.write_value;
        beats_issued <= beats_issued + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && beats_issued >= 2 * total_beats / 3) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < idle_pct(1'b0, beats_issued));
    end
  end

  always @(posedge clk) begin : watch
    name_beat_t taken;
    hnfs_res_t  res;
    hnfs_res_t  want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        taken.action = in_action;
        taken.name_part = in_name_part;
        taken.name_byte = in_name_byte;
        taken.last_byte = in_last_byte;
        taken.write_enable = in_write_enable;
        taken.write_value = in_write_value;
        if (predict_flag_access(taken, res)) expected_results.push_back(res);
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result beat, bit_index", out_bit_index, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_access_valid !== want.access_valid)
            report_mismatch("access_valid", out_access_valid, want.access_valid);
          if (out_flag_before !== want.flag_before)
            report_mismatch("flag_before", out_flag_before, want.flag_before);
          if (out_flag_after !== want.flag_after)
            report_mismatch("flag_after", out_flag_after, want.flag_after);
          if (out_bit_index !== want.bit_index)
            report_mismatch("bit_index", out_bit_index, want.bit_index);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int unsigned pick;
    foreach (flags[i]) flags[i] = 1'b0;
    for (int p = 0; p < POOL_SIZE; p++) begin
      pool_grp_len[p] = $urandom_range(1, 4);
      pool_key_len[p] = $urandom_range(1, 4);
      for (int i = 0; i < 4; i++) begin
        pool_grp[p][i] = NAME_W'($urandom_range(1, 255));
        pool_key[p][i] = NAME_W'($urandom_range(1, 255));
      end
    end

    push_beat(ACT_BYTE, PART_GROUP, 8'h01, 1'b0, 1'b0, 1'b0);
    push_beat(ACT_BYTE, PART_KEY,   8'hFF, 1'b1, 1'b0, 1'b0);
    push_beat(ACT_BYTE, PART_GROUP, 8'h01, 1'b0, 1'b1, 1'b0);
    push_beat(ACT_BYTE, PART_KEY,   8'hFF, 1'b1, 1'b1, 1'b1);
    push_beat(ACT_BYTE, PART_GROUP, 8'h01, 1'b0, 1'b0, 1'b1);
    push_beat(ACT_BYTE, PART_KEY,   8'hFF, 1'b1, 1'b1, 1'b1);
    push_beat(ACT_BYTE, PART_GROUP, 8'h01, 1'b0, 1'b1, 1'b1);
    push_beat(ACT_BYTE, PART_KEY,   8'hFF, 1'b1, 1'b0, 1'b0);
    push_beat(ACT_BYTE, PART_KEY,   8'h80, 1'b1, 1'b1, 1'b1);
    push_beat(ACT_BYTE, PART_GROUP, 8'h7F, 1'b1, 1'b1, 1'b1);
    push_beat(ACT_BYTE, PART_GROUP, 8'h41, 1'b0, 1'b0, 1'b0);
    push_beat(ACT_BYTE, PART_KEY,   8'h42, 1'b0, 1'b0, 1'b0);
    push_beat(ACT_BYTE, PART_GROUP, 8'h43, 1'b1, 1'b1, 1'b1);
    push_beat(ACT_BYTE, PART_GROUP, 8'h00, 1'b0, 1'b0, 1'b0);
    push_beat(ACT_BYTE, PART_KEY,   8'h00, 1'b1, 1'b1, 1'b1);
    push_beat(ACT_BYTE, PART_GROUP, 8'h10, 1'b0, 1'b0, 1'b0);
    push_beat(ACT_CLEAR, PART_KEY,  8'hFF, 1'b1, 1'b1, 1'b1);
    push_beat(ACT_BYTE, PART_GROUP, 8'h01, 1'b0, 1'b0, 1'b0);
    push_beat(ACT_BYTE, PART_KEY,   8'hFF, 1'b1, 1'b0, 1'b0);
    push_beat(ACT_BYTE, PART_KEY,   8'h11, 1'b0, 1'b0, 1'b0);
    push_beat(ACT_BYTE, PART_KEY,   8'h22, 1'b1, 1'b1, 1'b0);

    while (pending_beats.size() < 420) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        pick = $urandom_range(0, POOL_SIZE - 1);
        push_name(pick, pool_grp_len[pick], pool_key_len[pick], 1'b0,
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else if (pick < 72) begin
        push_name(-1, $urandom_range(1, 4), $urandom_range(1, 4), 1'b0,
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else if (pick < 77) begin
        if ($urandom_range(0, 1))
          push_beat(ACT_BYTE, PART_GROUP, NAME_W'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
        push_beat(ACT_CLEAR, 1'($urandom_range(0, 1)), NAME_W'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else if (pick < 83) begin
        push_name(-1, 0, $urandom_range(1, 3), 1'b0, 1'($urandom_range(0, 1)), 1'b1);
      end else if (pick < 89) begin
        push_name(-1, $urandom_range(1, 3), 0, 1'b0, 1'($urandom_range(0, 1)), 1'b1);
      end else if (pick < 95) begin
        push_name(-1, $urandom_range(0, 2), $urandom_range(1, 3), 1'b1,
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        repeat ($urandom_range(1, 4))
          push_beat(($urandom_range(0, 7) == 0) ? ACT_CLEAR : ACT_BYTE,
                    1'($urandom_range(0, 1)), NAME_W'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
      end
    end
    total_beats = pending_beats.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_beats.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
